// ===== design/windowed_dequeue_rate_estimator_core_assert.svh =====
// Assertion macros for the windowed dequeue rate estimator.
// Included by the top level; no other dependencies.
`ifndef WINDOWED_DEQUEUE_RATE_ESTIMATOR_CORE_ASSERT_SVH
`define WINDOWED_DEQUEUE_RATE_ESTIMATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define WDRE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WDRE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WDRE_ASSERT_IMPL(lbl, ante, cons)
`define WDRE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/wdre_pkg.sv =====
// Shared types and constants of the windowed dequeue rate estimator.
// No dependencies.
package wdre_pkg;

    localparam int DIV_W = 48;
    localparam logic [31:0] RATE_RESET = 32'd512000;
    localparam logic [31:0] IDLE_MARK = 32'hFFFF_FFFF;
    localparam logic [47:0] RATE_SAT_Q = 48'd4294967;
    localparam logic [20:0] QDEL_SCALE = 21'd2048000;
    localparam logic [19:0] DELAY_MAX = 20'hF_FFFF;
    localparam logic [23:0] QDEL_MAX = 24'hFF_FFFF;
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_MIN_RATE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_UPDATE, S_DIV_GO, S_DIV_WAIT, S_FLOOR, S_QMUL, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_RATE, PH_TRANS, PH_DELAY, PH_QDEL
    } phase_t;

    // 1000 * quotient, saturating at 32 bits
    function automatic logic [31:0] scale_rate(input logic [DIV_W-1:0] q);
        logic [31:0] r;
        if (q > RATE_SAT_Q)
            r = 32'hFFFF_FFFF;
        else
            r = q[31:0] * 32'd1000;
        return r;
    endfunction

endpackage

// ===== design/wdre_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on wdre_pkg.
module wdre_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [wdre_pkg::DIV_W-1:0]   dividend,
    input  logic [31:0]                  divisor,
    output logic                         done,
    output logic [wdre_pkg::DIV_W-1:0]   quotient
);
    localparam int CNT_W = $clog2(wdre_pkg::DIV_W);

    logic [31:0]                rem_reg;
    logic [wdre_pkg::DIV_W-1:0] quo_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       run_reg;
    logic                       done_reg;
    logic [32:0]                shifted;
    logic                       fits;

    assign shifted = {rem_reg, quo_reg[wdre_pkg::DIV_W-1]};
    assign fits = shifted >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(wdre_pkg::DIV_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? 32'(shifted - {1'b0, divisor}) : shifted[31:0];
            quo_reg <= {quo_reg[wdre_pkg::DIV_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== design/windowed_dequeue_rate_estimator_core.sv =====
// Top level of the windowed dequeue rate estimator.
// Depends on wdre_pkg, wdre_div and the assertion macro header.
//
// One request is one 1 ms tick of queue counters. The tick is classified as
// a sent-byte delta, a busy slot or an idle slot and pushed into a ring of
// the last window_slots slots with running sums. Four 48-bit quotients
// (dequeue rate, transmission rate, per-slot delay, queue delay) go one
// after another through a single bit-serial divider. Each quotient is
// started, retires one quotient bit per cycle and is then seen done. Around
// the divisions a request passes through the accept, the window update,
// the rate floor, the queue-delay product and the output load. When every
// non-idle slot is busy the delay quotient is skipped. When the window is
// all idle only the queue delay is divided. A stalled result side holds the
// sequencer while the output register stays full. A new request is taken
// once the previous one has moved into the output register, so a result may
// wait there while the next tick is processed. Writing window_slots clears
// the window; write the registers only while no request is in flight.
`include "windowed_dequeue_rate_estimator_core_assert.svh"
module windowed_dequeue_rate_estimator_core #(
    parameter int MAX_WINDOW = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // tick input
    input  logic         s_tvalid,
    output logic         s_tready,
    // total_received_bytes[31:0], queue_bytes[55:32], qdisc_bytes[79:56],
    // head_id[95:80], head_dst[127:96]
    input  logic [127:0] s_tdata,
    // head_present[0]
    input  logic         s_tuser,
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // tx_rate_bps[31:0], trans_rate_bps[63:32], slot_delay_us[83:64],
    // queue_delay_ms_q8[107:84], head_age_ms[123:108], zero fill above
    output logic [127:0] m_tdata
);
    localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = 32 + PW;
    localparam int W_RESET = (32 > MAX_WINDOW) ? MAX_WINDOW : 32;
    localparam int DW = wdre_pkg::DIV_W;

    wdre_pkg::state_t state_reg, state_next;
    wdre_pkg::phase_t phase_reg, phase_next;

    // configuration
    logic [CW-1:0]    w_reg;
    logic [31:0]      min_rate_reg;

    // window state
    logic [31:0]      ring [MAX_WINDOW];
    logic [31:0]      rd_data_reg;
    logic [PW-1:0]    ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CW-1:0]    idle_reg;
    logic [CW-1:0]    busy_reg;
    logic [31:0]      last_sent_reg;
    logic [15:0]      last_id_reg;
    logic [31:0]      last_dst_reg;
    logic [15:0]      age_reg;
    logic [31:0]      rate_reg;
    logic [31:0]      trans_reg;
    logic [19:0]      delay_reg;

    // per-request payload
    logic [31:0]      slot_reg;
    logic [23:0]      qb_reg;
    logic [23:0]      db_reg;
    logic [45:0]      qmul_reg;
    logic [23:0]      qdel_reg;

    logic             m_tvalid_reg;
    logic [127:0]     out_data_reg;

    // handshake decode
    logic             accept;
    logic             cfg_wr;
    logic             div_start;
    logic             div_done;
    logic [DW-1:0]    div_q;
    logic [DW-1:0]    div_dividend;
    logic [31:0]      div_divisor;
    logic             out_load;

    // tick classification
    logic [31:0]      in_total;
    logic [23:0]      in_qb;
    logic [31:0]      sent;
    logic [31:0]      slot;
    logic [PW-1:0]    eff_ptr;

    // window update
    logic             full;
    logic             drop_busy, drop_idle, drop_bytes;
    logic             add_busy, add_idle, add_bytes;
    logic [SUM_W-1:0] sum_upd;
    logic [CW-1:0]    idle_upd;
    logic [CW-1:0]    busy_upd;
    logic [CW-1:0]    count_upd;
    logic [CW-1:0]    ptr_inc;
    logic [CW-1:0]    nonidle;
    logic [31:0]      floor_rate;
    logic [31:0]      delay_full;
    logic [6:0]       w_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = (state_reg == wdre_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        unique case (paddr[2])
            wdre_pkg::REG_WINDOW:   prdata = 32'(w_reg);
            wdre_pkg::REG_MIN_RATE: prdata = min_rate_reg;
            default:                prdata = '0;
        endcase
    end

    // window write from pwdata[6:0]: zero acts as one, anything above the ring size clamps
    assign w_wr = pwdata[6:0];

    // sent total; only a strictly larger value counts as progress
    assign in_total = s_tdata[31:0];
    assign in_qb    = s_tdata[55:32];
    assign sent     = in_total - {8'd0, in_qb};

    always_comb
    begin
        priority if (sent > last_sent_reg)
            slot = ((sent - last_sent_reg) == wdre_pkg::IDLE_MARK)
                 ? wdre_pkg::IDLE_MARK - 32'd1 : sent - last_sent_reg;
        else if (in_qb != 24'd0)
            slot = 32'd0;
        else
            slot = wdre_pkg::IDLE_MARK;
    end

    assign eff_ptr = (CW'(ptr_reg) >= w_reg) ? '0 : ptr_reg;

    // drop the oldest slot once the window is full, then add this one
    assign full       = count_reg >= w_reg;
    assign drop_busy  = full && (rd_data_reg == 32'd0);
    assign drop_idle  = full && (rd_data_reg == wdre_pkg::IDLE_MARK);
    assign drop_bytes = full && !drop_busy && !drop_idle;
    assign add_busy   = (slot_reg == 32'd0);
    assign add_idle   = (slot_reg == wdre_pkg::IDLE_MARK);
    assign add_bytes  = !add_busy && !add_idle;

    assign sum_upd = sum_reg
                   - (drop_bytes ? SUM_W'(rd_data_reg) : '0)
                   + (add_bytes ? SUM_W'(slot_reg) : '0);
    assign idle_upd  = idle_reg - CW'(drop_idle) + CW'(add_idle);
    assign busy_upd  = busy_reg - CW'(drop_busy) + CW'(add_busy);
    assign count_upd = full ? w_reg : count_reg + CW'(1);
    assign ptr_inc   = CW'(ptr_reg) + CW'(1);

    assign nonidle    = count_reg - idle_reg;
    assign floor_rate = (min_rate_reg == 32'd0) ? 32'd1 : min_rate_reg;
    assign delay_full = 32'(w_reg) * 32'd1000;

    // divider operands per phase
    always_comb
    begin
        unique case (phase_reg)
            wdre_pkg::PH_RATE:
            begin
                div_dividend = DW'({sum_reg, 3'b000});
                div_divisor  = 32'(w_reg - idle_reg);
            end
            wdre_pkg::PH_TRANS:
            begin
                div_dividend = DW'({sum_reg, 3'b000});
                div_divisor  = 32'(w_reg);
            end
            wdre_pkg::PH_DELAY:
            begin
                div_dividend = DW'(32'(nonidle) * 32'd1000);
                div_divisor  = 32'(nonidle - busy_reg);
            end
            wdre_pkg::PH_QDEL:
            begin
                div_dividend = DW'(qmul_reg);
                div_divisor  = rate_reg;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = 32'd1;
            end
        endcase
    end

    wdre_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wdre_pkg::S_IDLE;
            phase_reg <= wdre_pkg::PH_RATE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            wdre_pkg::S_IDLE:
                if (s_tvalid)
                    state_next = wdre_pkg::S_UPDATE;
            wdre_pkg::S_UPDATE:
                if (idle_upd < count_upd)
                begin
                    phase_next = wdre_pkg::PH_RATE;
                    state_next = wdre_pkg::S_DIV_GO;
                end
                else
                    state_next = wdre_pkg::S_FLOOR;
            wdre_pkg::S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = wdre_pkg::S_DIV_WAIT;
            end
            wdre_pkg::S_DIV_WAIT:
                if (div_done)
                begin
                    unique case (phase_reg)
                        wdre_pkg::PH_RATE:
                        begin
                            phase_next = wdre_pkg::PH_TRANS;
                            state_next = wdre_pkg::S_DIV_GO;
                        end
                        wdre_pkg::PH_TRANS:
                            if (busy_reg < nonidle)
                            begin
                                phase_next = wdre_pkg::PH_DELAY;
                                state_next = wdre_pkg::S_DIV_GO;
                            end
                            else
                                state_next = wdre_pkg::S_FLOOR;
                        wdre_pkg::PH_DELAY:
                            state_next = wdre_pkg::S_FLOOR;
                        wdre_pkg::PH_QDEL:
                            state_next = wdre_pkg::S_DONE;
                        default:
                            state_next = wdre_pkg::S_IDLE;
                    endcase
                end
            wdre_pkg::S_FLOOR:
                state_next = wdre_pkg::S_QMUL;
            wdre_pkg::S_QMUL:
            begin
                phase_next = wdre_pkg::PH_QDEL;
                state_next = wdre_pkg::S_DIV_GO;
            end
            wdre_pkg::S_DONE:
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = wdre_pkg::S_IDLE;
                end
            default:
                state_next = wdre_pkg::S_IDLE;
        endcase
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= CW'(W_RESET);
            min_rate_reg  <= wdre_pkg::RATE_RESET;
            ptr_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            idle_reg      <= '0;
            busy_reg      <= '0;
            last_sent_reg <= '0;
            last_id_reg   <= '0;
            last_dst_reg  <= '0;
            age_reg       <= '0;
            rate_reg      <= wdre_pkg::RATE_RESET;
            trans_reg     <= '0;
            delay_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == wdre_pkg::REG_WINDOW)
                begin
                    if (w_wr == 7'd0)
                        w_reg <= CW'(1);
                    else if (32'(w_wr) > 32'(MAX_WINDOW))
                        w_reg <= CW'(MAX_WINDOW);
                    else
                        w_reg <= CW'(w_wr);
                    ptr_reg   <= '0;
                    count_reg <= '0;
                    sum_reg   <= '0;
                    idle_reg  <= '0;
                    busy_reg  <= '0;
                end
                else
                    min_rate_reg <= pwdata;
            end

            if (accept)
            begin
                // head age: restart on a new head or no head, hold at the ceiling
                if (s_tuser)
                begin
                    if (s_tdata[95:80] != last_id_reg || s_tdata[127:96] != last_dst_reg)
                    begin
                        last_id_reg  <= s_tdata[95:80];
                        last_dst_reg <= s_tdata[127:96];
                        age_reg      <= '0;
                    end
                    else if (age_reg != 16'hFFFF)
                        age_reg <= age_reg + 16'd1;
                end
                else
                    age_reg <= '0;
                last_sent_reg <= sent;
                ptr_reg       <= eff_ptr;
            end

            if (state_reg == wdre_pkg::S_UPDATE)
            begin
                sum_reg   <= sum_upd;
                idle_reg  <= idle_upd;
                busy_reg  <= busy_upd;
                count_reg <= count_upd;
                ptr_reg   <= (ptr_inc == w_reg) ? '0 : PW'(ptr_inc);
            end

            if (state_reg == wdre_pkg::S_DIV_WAIT && div_done)
            begin
                unique case (phase_reg)
                    wdre_pkg::PH_RATE:
                        rate_reg <= wdre_pkg::scale_rate(div_q);
                    wdre_pkg::PH_TRANS:
                    begin
                        trans_reg <= wdre_pkg::scale_rate(div_q);
                        // every non-idle slot busy: a whole window per send
                        if (!(busy_reg < nonidle))
                            delay_reg <= (delay_full > 32'(wdre_pkg::DELAY_MAX))
                                       ? wdre_pkg::DELAY_MAX : delay_full[19:0];
                    end
                    wdre_pkg::PH_DELAY:
                        delay_reg <= (div_q > DW'(wdre_pkg::DELAY_MAX))
                                   ? wdre_pkg::DELAY_MAX : div_q[19:0];
                    default:
                        delay_reg <= delay_reg;
                endcase
            end

            if (state_reg == wdre_pkg::S_FLOOR)
            begin
                if (rate_reg < floor_rate)
                    rate_reg <= floor_rate;
                if (trans_reg < floor_rate)
                    trans_reg <= floor_rate;
            end

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // ring memory: read at the slot being replaced, write the new slot
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= ring[eff_ptr];
        if (state_reg == wdre_pkg::S_UPDATE)
            ring[ptr_reg] <= slot_reg;
    end

    // per-request payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg <= slot;
            qb_reg   <= in_qb;
            db_reg   <= s_tdata[79:56];
        end
        if (state_reg == wdre_pkg::S_QMUL)
            qmul_reg <= 46'({1'b0, qb_reg} + {1'b0, db_reg}) * 46'(wdre_pkg::QDEL_SCALE);
        if (state_reg == wdre_pkg::S_DIV_WAIT && div_done && phase_reg == wdre_pkg::PH_QDEL)
            qdel_reg <= (div_q > DW'(wdre_pkg::QDEL_MAX)) ? wdre_pkg::QDEL_MAX : div_q[23:0];
        if (out_load)
            out_data_reg <= {4'd0, age_reg, qdel_reg, delay_reg, trans_reg, rate_reg};
    end

    // the window never holds more slots than its length
    `WDRE_ASSERT_IMPL(a_count_in_window, 1'b1, count_reg <= w_reg)
    // idle and busy slots are a subset of the held slots
    `WDRE_ASSERT_IMPL(a_class_counts,
        1'b1, ({1'b0, idle_reg} + {1'b0, busy_reg}) <= {1'b0, count_reg})
    // a quotient only completes while the sequencer waits for it
    `WDRE_ASSERT_IMPL(a_div_done_waits, div_done, state_reg == wdre_pkg::S_DIV_WAIT)
    // an accepted tick always updates the window next
    `WDRE_ASSERT_NEXT(a_accept_updates, accept, state_reg == wdre_pkg::S_UPDATE)
endmodule

// ===== sim/windowed_dequeue_rate_estimator_core_test.sv =====
// Self-checking testbench for the windowed dequeue rate estimator core.
// Depends on wdre_pkg and the windowed_dequeue_rate_estimator_core RTL.
`timescale 1ns / 100ps

module windowed_dequeue_rate_estimator_core_test;

    localparam int MAX_WIN = 64;
    localparam int LIMIT_CYCLES = 4000000;

    typedef struct packed {
        logic [31:0] total;
        logic [23:0] qbytes;
        logic [23:0] dbytes;
        logic        present;
        logic [15:0] hid;
        logic [31:0] hdst;
    } tick_t;

    typedef struct packed {
        logic [31:0] rate;
        logic [31:0] trans;
        logic [19:0] delay;
        logic [23:0] qdel;
        logic [15:0] age;
    } estimate_t;

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;

    windowed_dequeue_rate_estimator_core u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Predictor state, kept at the block's widths
    logic [6:0]  win_len;
    logic [31:0] rate_floor;
    logic [31:0] slots [MAX_WIN];
    logic [6:0]  fill;
    logic [5:0]  wr_ptr;
    logic [37:0] byte_total;
    logic [6:0]  n_idle;
    logic [6:0]  n_busy;
    logic [31:0] prev_sent;
    logic [15:0] prev_hid;
    logic [31:0] prev_hdst;
    logic [15:0] age_ms;
    logic [31:0] tx_rate;
    logic [31:0] trans_rate;
    logic [19:0] delay_us;

    // Expected estimates in order; the sender adds, the checker takes
    estimate_t expected_ring [64];
    int  exp_wr_cnt = 0;
    int  exp_rd_cnt = 0;
    int  mismatches = 0;
    int  cycles = 0;
    int  send_idle_pct;
    int  recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cap the run length; a hang counts as a failure
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("** windowed_dequeue_rate_estimator_core: FAILED **");
            $finish;
        end
    end

    function automatic void clear_window();
        fill = '0;
        wr_ptr = '0;
        byte_total = '0;
        n_idle = '0;
        n_busy = '0;
    endfunction

    function automatic void predictor_reset();
        win_len = 7'd32;
        rate_floor = wdre_pkg::RATE_RESET;
        clear_window();
        prev_sent = '0;
        prev_hid = '0;
        prev_hdst = '0;
        age_ms = '0;
        tx_rate = wdre_pkg::RATE_RESET;
        trans_rate = '0;
        delay_us = '0;
    endfunction

    function automatic logic [31:0] rate_of(logic [63:0] bits, logic [63:0] div);
        logic [63:0] r;
        r = (bits / div) * 64'd1000;
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    // Work out the estimate that one tick produces and advance the state
    function automatic estimate_t estimate_tick(tick_t t);
        estimate_t   e;
        logic [31:0] sent;
        logic [31:0] slot;
        logic [31:0] old;
        logic [31:0] fl;
        logic [31:0] nonidle;
        logic [63:0] d;
        logic [63:0] q;
        if (t.present)
        begin
            if (t.hid != prev_hid || t.hdst != prev_hdst)
            begin
                prev_hid = t.hid;
                prev_hdst = t.hdst;
                age_ms = '0;
            end
            else if (age_ms != 16'hFFFF)
                age_ms++;
        end
        else
            age_ms = '0;

        sent = t.total - {8'd0, t.qbytes};
        if (sent > prev_sent)
        begin
            slot = sent - prev_sent;
            if (slot == wdre_pkg::IDLE_MARK)
                slot = wdre_pkg::IDLE_MARK - 32'd1;
        end
        else if (t.qbytes != 0)
            slot = '0;
        else
            slot = wdre_pkg::IDLE_MARK;
        prev_sent = sent;

        if (wr_ptr >= win_len)
            wr_ptr = '0;
        if (fill >= win_len)
        begin
            old = slots[wr_ptr];
            if (old == 0)
                n_busy--;
            else if (old == wdre_pkg::IDLE_MARK)
                n_idle--;
            else
                byte_total -= old;
            fill = win_len - 7'd1;
        end
        slots[wr_ptr] = slot;
        if (slot == 0)
            n_busy++;
        else if (slot == wdre_pkg::IDLE_MARK)
            n_idle++;
        else
            byte_total += slot;
        fill++;
        wr_ptr = 6'((32'(wr_ptr) + 1) % 32'(win_len));

        if (n_idle < fill)
        begin
            nonidle = 32'(fill - n_idle);
            tx_rate = rate_of({byte_total, 3'b0}, 64'(win_len - n_idle));
            trans_rate = rate_of({byte_total, 3'b0}, 64'(win_len));
            if (32'(n_busy) < nonidle)
                d = 64'(1000 * nonidle) / 64'(nonidle - 32'(n_busy));
            else
                d = 64'(win_len) * 1000;
            delay_us = (d > 64'hF_FFFF) ? 20'hF_FFFF : d[19:0];
        end

        fl = (rate_floor == 0) ? 32'd1 : rate_floor;
        if (tx_rate < fl)
            tx_rate = fl;
        if (trans_rate < fl)
            trans_rate = fl;

        q = ((64'(t.qbytes) + 64'(t.dbytes)) * 64'd2048000) / 64'(tx_rate);
        e.rate = tx_rate;
        e.trans = trans_rate;
        e.delay = delay_us;
        e.qdel = (q > 64'hFF_FFFF) ? 24'hFF_FFFF : q[23:0];
        e.age = age_ms;
        return e;
    endfunction

    // Check each accepted result against the oldest estimate
    always @(posedge clk)
    begin
        estimate_t want;
        estimate_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[83:64],
                   m_tdata[107:84], m_tdata[123:108]};
            if (exp_wr_cnt == exp_rd_cnt)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                want = expected_ring[exp_rd_cnt[5:0]];
                exp_rd_cnt++;
                if (got !== want || m_tdata[127:124] !== 4'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: rate %0d/%0d trans %0d/%0d delay %0d/%0d",
                                  " qdel %0d/%0d age %0d/%0d (exp/act)"},
                                 want.rate, got.rate, want.trans, got.trans,
                                 want.delay, got.delay, want.qdel, got.qdel,
                                 want.age, got.age);
                end
            end
        end
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Present the request until accepted, with random gaps before it
    task automatic send_tick(tick_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {t.hdst, t.hid, t.dbytes, t.qbytes, t.total};
        s_tuser <= t.present;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_ring[exp_wr_cnt[5:0]] = estimate_tick(t);
        exp_wr_cnt++;
    endtask

    // Drop the request line and wait for every estimate
    task automatic drain();
        s_tvalid <= 1'b0;
        while (exp_wr_cnt != exp_rd_cnt)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic addr_sel, logic [31:0] value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {addr_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr_sel == wdre_pkg::REG_WINDOW)
        begin
            win_len = (value[6:0] == 0) ? 7'd1 :
                      (value[6:0] > MAX_WIN) ? 7'(MAX_WIN) : value[6:0];
            clear_window();
        end
        else
            rate_floor = value;
    endtask

    function automatic tick_t random_tick();
        tick_t t;
        t.total = $urandom;
        t.qbytes = 24'($urandom);
        t.dbytes = 24'($urandom);
        t.present = 1'($urandom_range(1));
        t.hid = 16'($urandom);
        t.hdst = $urandom;
        return t;
    endfunction

    // Realistic traffic: counter advances, small queues, same head often
    function automatic tick_t traffic_tick(ref logic [31:0] rx, ref tick_t last);
        tick_t t;
        int    mode;
        mode = $urandom_range(9);
        if (mode < 5)
            rx += $urandom_range(20000);
        t = last;
        t.total = rx;
        case ($urandom_range(3))
            0: t.qbytes = 0;
            1: t.qbytes = 24'($urandom_range(3000));
            2: t.qbytes = last.qbytes;
            default: t.qbytes = 24'($urandom_range(200000));
        endcase
        t.dbytes = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(50000));
        t.present = ($urandom_range(4) != 0);
        if ($urandom_range(3) == 0)
        begin
            t.hid = 16'($urandom);
            t.hdst = ($urandom_range(1) != 0) ? last.hdst : 32'($urandom);
        end
        if (mode == 9)
            t = random_tick();
        last = t;
        return t;
    endfunction

    task automatic test_directed();
        tick_t t;
        t = '0;
        send_tick(t);                       // idle slot, all idle window
        t.qbytes = 24'hFF_FFFF;
        t.dbytes = 24'hFF_FFFF;
        send_tick(t);                       // sent total wraps: large byte delta, full queue counters
        t = '{32'hFFFF_FFFF, 24'd0, 24'd0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF};
        send_tick(t);                       // large byte delta, new head
        send_tick(t);                       // same head, age grows
        send_tick(t);
        t.present = 1'b0;
        send_tick(t);                       // head absent clears age
        t.present = 1'b1;
        send_tick(t);
        t.total = 32'd100;                  // counter wrapped: no progress
        t.qbytes = 24'd5;
        send_tick(t);
        t.total = 32'd5000;
        t.qbytes = 24'd0;
        t.hid = 16'h0;
        send_tick(t);
        t.hdst = 32'h0;
        send_tick(t);
    endtask

    task automatic test_config_extremes();
        tick_t t;
        logic [31:0] rx;
        write_reg(wdre_pkg::REG_WINDOW, 32'd0);       // zero acts as one
        write_reg(wdre_pkg::REG_MIN_RATE, 32'd0);     // zero floor acts as one
        t = '0;
        rx = 0;
        for (int i = 0; i < 6; i++)
            send_tick(traffic_tick(rx, t));
        write_reg(wdre_pkg::REG_WINDOW, 32'h7F);      // above the maximum
        write_reg(wdre_pkg::REG_MIN_RATE, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++)
            send_tick(traffic_tick(rx, t));
        write_reg(wdre_pkg::REG_WINDOW, 32'd64);
        write_reg(wdre_pkg::REG_MIN_RATE, 32'd1);
        for (int i = 0; i < 6; i++)
            send_tick(traffic_tick(rx, t));
    endtask

    task automatic test_random_phase(int n_ticks, int idle_pct, int stall_pct);
        tick_t t;
        logic [31:0] rx;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_reg(wdre_pkg::REG_WINDOW,
                  $urandom_range(1, 3) == 1 ? 32'($urandom_range(1, 8)) :
                  32'($urandom_range(0, 127)));
        write_reg(wdre_pkg::REG_MIN_RATE,
                  ($urandom_range(1) != 0) ? 32'($urandom_range(1, 2000000)) :
                  32'($urandom));
        t = '0;
        rx = $urandom;
        for (int i = 0; i < n_ticks; i++)
        begin
            send_tick(traffic_tick(rx, t));
            // Let the result side catch up once in a while
            if ($urandom_range(199) == 0)
            begin
                s_tvalid <= 1'b0;
                while (exp_wr_cnt != exp_rd_cnt)
                    @(posedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        predictor_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        for (int k = 0; k < 2; k++)
        begin
            test_random_phase(230, 0, 0);
            test_random_phase(220, 71, 0);
            test_random_phase(220, 0, 71);
            test_random_phase(220, 38, 38);
        end
        drain();

        if (mismatches == 0)
            $display("** windowed_dequeue_rate_estimator_core: PASSED **");
        else
            $display("** windowed_dequeue_rate_estimator_core: FAILED **");
        $finish;
    end
endmodule
